>>> design/ahfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_pkg
// Shared types and constants for the async HDLC frame receiver.
// ----------------------------------------------------------------------------
package ahfr_pkg;

  localparam int MaxFrameBytes = 256;
  localparam int MaxRingSlots  = 64;

  localparam int ByteW  = 8;
  localparam int CountW = 9;
  localparam int IndexW = 8;
  localparam int SlotW  = 6;
  localparam int RingW  = 7;
  localparam int TimeW  = 32;
  localparam int EventW = 2;
  localparam int KindW  = 2;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 3;

  localparam logic [EventW-1:0] EvByte    = 2'd0;
  localparam logic [EventW-1:0] EvCtlEnd  = 2'd1;
  localparam logic [EventW-1:0] EvPipeEnd = 2'd2;

  localparam logic [KindW-1:0] KindAwait = 2'd0;
  localparam logic [KindW-1:0] KindCtl   = 2'd1;
  localparam logic [KindW-1:0] KindPipe  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgStart    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEnd      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEscape   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMask     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPipeId   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSlots    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgPerBlock = 3'd6;

  typedef struct packed {
    logic rewind;
    logic advance;
  } ring_ctrl_t;

  typedef struct packed {
    logic [SlotW-1:0] fill_slot;
    logic             block_done;
    logic [SlotW-1:0] block_start_slot;
  } ring_stat_t;

endpackage

>>> design/ahfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_in_if / ahfr_out_if
// Valid/ready channels for received words and decoded result words.
// ----------------------------------------------------------------------------
interface ahfr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  rx_byte;
  logic [31:0] time_us;

  modport source (output valid, command, rx_byte, time_us, input ready);
  modport sink   (input valid, command, rx_byte, time_us, output ready);
endinterface

interface ahfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic        is_pipe;
  logic [5:0]  slot;
  logic [8:0]  frame_length;
  logic [31:0] arrival_stamp;
  logic        block_done;
  logic [5:0]  block_start_slot;
  logic        overflowed;

  modport source (output valid, event_res, data_byte, byte_index, is_pipe, slot,
                  frame_length, arrival_stamp, block_done, block_start_slot,
                  overflowed, input ready);
  modport sink   (input valid, event_res, data_byte, byte_index, is_pipe, slot,
                  frame_length, arrival_stamp, block_done, block_start_slot,
                  overflowed, output ready);
endinterface

>>> design/async_hdlc_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_hdlc_frame_receiver
// Async HDLC byte unstuffing deframer with pipe ring bookkeeping.
// ----------------------------------------------------------------------------
// One received word is taken per clock. A word is held in an input register and
// decoded against the frame state into the result register, where its result
// (if any) appears; the result register's handshake is the only thing that can
// hold the input side off.
// Configuration must be written while no word is in flight.
module async_hdlc_frame_receiver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ahfr_in_if.sink                      rx_i,
  ahfr_out_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [ahfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ahfr_pkg::CfgW-1:0]    cfg_data_i
);
  import ahfr_pkg::*;

  // configuration
  logic [7:0] start_q, end_q, esc_code_q, mask_q, pipe_id_q;
  logic [6:0] slots_q, per_block_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 8'd126;
      end_q       <= 8'd125;
      esc_code_q  <= 8'd124;
      mask_q      <= 8'd32;
      pipe_id_q   <= 8'd0;
      slots_q     <= 7'd64;
      per_block_q <= 7'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStart:    start_q     <= cfg_data_i;
        CfgEnd:      end_q       <= cfg_data_i;
        CfgEscape:   esc_code_q  <= cfg_data_i;
        CfgMask:     mask_q      <= cfg_data_i;
        CfgPipeId:   pipe_id_q   <= cfg_data_i;
        CfgSlots:    slots_q     <= cfg_data_i[6:0];
        CfgPerBlock: per_block_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic             s1_valid_q, s1_cmd_q;
  logic [ByteW-1:0] s1_byte_q;
  logic [TimeW-1:0] s1_time_q;
  logic             out_valid_q;
  logic             advance, rx_take;

  assign advance    = s1_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !s1_valid_q || advance;
  assign rx_take    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      s1_cmd_q  <= rx_i.command;
      s1_byte_q <= rx_i.rx_byte;
      s1_time_q <= rx_i.time_us;
    end
  end

  // frame state
  logic              esc_q, esc_d, in_frame_q, in_frame_d, ovf_q, ovf_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [CountW-1:0] count_q, count_d;

  ring_ctrl_t ring_ctrl;
  ring_stat_t ring_stat;

  ahfr_ring u_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ring_ctrl),
    .ring_slots_i (slots_q),
    .per_block_i  (per_block_q),
    .stat_o       (ring_stat)
  );

  logic              emit, store;
  logic [ByteW-1:0]  store_val;
  logic [EventW-1:0] r_event;
  logic [ByteW-1:0]  r_data;
  logic [IndexW-1:0] r_index;
  logic              r_pipe, r_block_done, r_ovf;
  logic [SlotW-1:0]  r_slot, r_block_slot;
  logic [CountW-1:0] r_len;
  logic [TimeW-1:0]  r_stamp;

  always_comb begin
    esc_d        = esc_q;
    in_frame_d   = in_frame_q;
    ovf_d        = ovf_q;
    kind_d       = kind_q;
    count_d      = count_q;
    ring_ctrl    = '0;
    emit         = 1'b0;
    store        = 1'b0;
    store_val    = s1_byte_q;
    r_event      = EvByte;
    r_data       = '0;
    r_index      = '0;
    r_pipe       = 1'b0;
    r_slot       = '0;
    r_len        = '0;
    r_stamp      = '0;
    r_block_done = 1'b0;
    r_block_slot = '0;
    r_ovf        = 1'b0;

    if (s1_cmd_q) begin
      ring_ctrl.rewind = 1'b1;
    end else if (in_frame_q && s1_byte_q == end_q) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      kind_d     = KindAwait;
      r_len      = count_q;
      r_ovf      = ovf_q;
      if (kind_q == KindCtl) begin
        emit    = 1'b1;
        r_event = EvCtlEnd;
      end else if (kind_q == KindPipe) begin
        emit              = 1'b1;
        ring_ctrl.advance = 1'b1;
        r_event           = EvPipeEnd;
        r_pipe            = 1'b1;
        r_slot            = ring_stat.fill_slot;
        r_stamp           = s1_time_q;
        r_block_done      = ring_stat.block_done;
        r_block_slot      = ring_stat.block_start_slot;
      end
    end else if (s1_byte_q == start_q) begin
      in_frame_d = 1'b1;
      esc_d      = 1'b0;
      kind_d     = KindAwait;
      count_d    = '0;
      ovf_d      = 1'b0;
    end else if (!in_frame_q) begin
      // idle line: dropped
    end else if (kind_q == KindAwait) begin
      kind_d = (s1_byte_q == pipe_id_q) ? KindPipe : KindCtl;
      store  = 1'b1;
    end else if (s1_byte_q == esc_code_q) begin
      esc_d = 1'b1;
    end else if (esc_q) begin
      esc_d     = 1'b0;
      store     = 1'b1;
      store_val = s1_byte_q ^ mask_q;
    end else begin
      store = 1'b1;
    end

    if (store) begin
      if (count_q >= CountW'(MaxFrameBytes)) begin
        ovf_d = 1'b1;
      end else begin
        emit    = 1'b1;
        r_event = EvByte;
        r_data  = store_val;
        r_index = count_q[IndexW-1:0];
        r_pipe  = (kind_d == KindPipe);
        r_slot  = (kind_d == KindPipe) ? ring_stat.fill_slot : '0;
        count_d = count_q + CountW'(1);
      end
    end

    if (!advance) begin
      ring_ctrl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      in_frame_q <= 1'b0;
      ovf_q      <= 1'b0;
      kind_q     <= KindAwait;
      count_q    <= '0;
    end else if (advance) begin
      esc_q      <= esc_d;
      in_frame_q <= in_frame_d;
      ovf_q      <= ovf_d;
      kind_q     <= kind_d;
      count_q    <= count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_o.event_res        <= r_event;
      res_o.data_byte        <= r_data;
      res_o.byte_index       <= r_index;
      res_o.is_pipe          <= r_pipe;
      res_o.slot             <= r_slot;
      res_o.frame_length     <= r_len;
      res_o.arrival_stamp    <= r_stamp;
      res_o.block_done       <= r_block_done;
      res_o.block_start_slot <= r_block_slot;
      res_o.overflowed       <= r_ovf;
    end
  end

  assign res_o.valid = out_valid_q;

  // checks
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxFrameBytes))
    else $error("byte count past frame limit");

  a_await_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_frame_q && kind_q == KindAwait) |-> (count_q == '0))
    else $error("bytes counted before frame id");

  a_block_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_o.block_done) |-> (res_o.event_res == EvPipeEnd))
    else $error("block flag on non-pipe result");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> out_valid_q)
    else $error("pending result lost");

endmodule

>>> design/ahfr_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfr_ring
// Pipe ring bookkeeping: fill slot, block start slot and packet counter.
// ----------------------------------------------------------------------------
module ahfr_ring (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ahfr_pkg::ring_ctrl_t  ctrl_i,
  input  logic [6:0]            ring_slots_i,
  input  logic [6:0]            per_block_i,
  output ahfr_pkg::ring_stat_t  stat_o
);
  import ahfr_pkg::*;

  logic [SlotW-1:0] fill_q, fill_d, block_q, block_d;
  logic [RingW-1:0] pkt_q, pkt_d;
  logic [RingW-1:0] slots_eff, per_eff, fill_inc, pkt_inc;
  logic [SlotW-1:0] fill_next;
  logic             done;

  always_comb begin
    if (ring_slots_i == '0) begin
      slots_eff = RingW'(1);
    end else if (ring_slots_i > RingW'(MaxRingSlots)) begin
      slots_eff = RingW'(MaxRingSlots);
    end else begin
      slots_eff = ring_slots_i;
    end
    per_eff   = (per_block_i == '0) ? RingW'(1) : per_block_i;
    fill_inc  = RingW'(fill_q) + RingW'(1);
    fill_next = (fill_inc >= slots_eff) ? '0 : fill_inc[SlotW-1:0];
    pkt_inc   = pkt_q + RingW'(1);
    done      = (pkt_inc == per_eff);
  end

  always_comb begin
    fill_d  = fill_q;
    block_d = block_q;
    pkt_d   = pkt_q;
    if (ctrl_i.rewind) begin
      fill_d  = '0;
      block_d = '0;
      pkt_d   = '0;
    end else if (ctrl_i.advance) begin
      fill_d = fill_next;
      pkt_d  = done ? '0 : pkt_inc;
      if (done) begin
        block_d = fill_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      block_q <= '0;
      pkt_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      block_q <= block_d;
      pkt_q   <= pkt_d;
    end
  end

  assign stat_o.fill_slot        = fill_q;
  assign stat_o.block_done       = done;
  assign stat_o.block_start_slot = done ? block_q : '0;

endmodule
